// ----- design/zsn_pkg.sv -----
// package for the z-score normalizer: states, item types and fixed widths
`timescale 1ns / 1ps
package zsn_pkg;
  localparam int SAMPLE_BITS = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUMSQ,
    ST_VARDIV,
    ST_SQRT,
    ST_EMIT_RD,
    ST_EMIT_DIV,
    ST_EMIT_OUT
  } zsn_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } sample_item_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               clipped;
    logic               dropped_any;
    logic               final_res;
  } zscore_item_t;
endpackage

// ----- design/zsn_if.sv -----
// valid/ready channel interface with a generic payload
`timescale 1ns / 1ps
interface zsn_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/zsn_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module zsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- design/z_score_normalizer.sv -----
// z-score normalizer top level: sample store, statistics and serial divide/sqrt
//
// usage: samples stream in on the input channel (sample, last); each is stored
// and summed, one item per cycle while loading. an item with last set closes
// the column: the block then computes the mean, the population variance and
// its square root, and emits every stored sample as (x-mean)/std in Q4.11 on
// the result channel, in arrival order, final_res set on the last one.
// samples beyond MAX_SAMPLES are dropped and dropped_any is set for the column.
// after last the block runs the mean divide, a walk over the store summing the
// squared deviations, the variance divide and the root, then the results in
// turn. each result takes a 54-step restoring divide plus a store read; the
// mean and the variance each take one such divide, and the root a 29-step
// loop, one result bit per cycle. the input is closed while a column is
// processed and reopens once the final result of the column is registered.
// reset (synchronous, active low) clears the sum, count and flags; store
// contents are not cleared. a result waits in its output register while the
// receiver stalls; the next result waits for it, the next column does not.
module z_score_normalizer
  import zsn_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input logic clk,
  input logic rst_n,
  zsn_if.sink   in_ch,
  zsn_if.source out_ch
);
  localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = SAMPLE_BITS + CW;          // running sum
  localparam int XW  = SAMPLE_BITS + 9;           // x*256 - mean, signed
  localparam int QW  = 2 * XW + CW;               // sum of squares
  localparam int DW  = 2 * XW + 4;                // divide work width
  localparam int DCW = $clog2(DW + 1);

  zsn_state_t state_r, state_nxt;

  logic [CW-1:0] count_r;
  logic [SW-1:0] sum_r;
  logic          ovf_r;
  logic [AW-1:0] idx_r;
  logic          first_r;

  // serial divider: num / den, restoring, one bit per step
  logic [DW-1:0] dnum_r, drem_r, dden_r;
  logic [DCW-1:0] dcnt_r;
  logic          dsign_r, dbusy_r;

  logic signed [XW-1:0] mean_r;
  logic [QW-1:0] sumsq_r;
  logic [QW-1:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [QW-1:0] sd_r;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          ram_addr;
  logic                   ram_we;

  logic [15:0] out_z_r;
  logic        out_clip_r, out_valid_r, out_final_r, out_drop_r;
  logic        mult_ph_r;
  logic [2*XW-1:0] dev_sq;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  wire full     = (count_r == CW'(MAX_SAMPLES));

  assign in_ch.ready = (state_r == ST_LOAD);
  assign ram_we  = in_fire && !full;
  assign ram_addr = (state_r == ST_LOAD) ? count_r[AW-1:0] : idx_r;

  zsn_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_ch.data.sample[SAMPLE_BITS-1:0]), .rdata(rd_data)
  );

  // deviation of the stored sample, units 2^-8
  logic signed [XW-1:0] dev;
  logic [XW-1:0] dev_mag;
  assign dev = (XW'($signed(rd_data)) <<< 8) - mean_r;
  assign dev_mag = dev[XW-1] ? XW'(-dev) : XW'(dev);
  assign dev_sq = dev_mag * dev_mag;

  // divider step
  logic [DW:0] dtrial;
  assign dtrial = {drem_r, dnum_r[DW-1]} - {1'b0, dden_r};
  wire div_done = !dbusy_r;

  // sqrt step values
  logic [QW-1:0] sq_sum;
  assign sq_sum = sq_res_r + sq_bit_r;

  // quotient magnitude, ties away from zero: mean and z numerators pre-biased
  logic [DW-1:0] q_mag;
  assign q_mag = dnum_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_fire && in_ch.data.last) begin
        state_nxt = ST_SUMSQ;
      end
      ST_SUMSQ:    if (div_done && !first_r && mult_ph_r && idx_r == AW'(count_r - 1'b1)
                       && !dbusy_r) state_nxt = ST_VARDIV;
      ST_VARDIV:   if (div_done && !first_r) state_nxt = ST_SQRT;
      ST_SQRT:     if (sq_bit_r == '0 && !first_r) state_nxt = ST_EMIT_RD;
      ST_EMIT_RD:  state_nxt = ST_EMIT_DIV;
      ST_EMIT_DIV: if (div_done && !first_r) state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: if (!out_valid_r) begin
        state_nxt = (idx_r == AW'(count_r - 1'b1)) ? ST_LOAD : ST_EMIT_RD;
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: mean divide is started at last, then sumsq walk, etc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      first_r     <= 1'b0;
      dbusy_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mult_ph_r   <= 1'b0;
    end else begin
      if (out_fire) out_valid_r <= 1'b0;
      if (dbusy_r) begin
        dnum_r <= {dnum_r[DW-2:0], ~dtrial[DW]};
        drem_r <= dtrial[DW] ? {drem_r[DW-2:0], dnum_r[DW-1]} : dtrial[DW-1:0];
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == DCW'(1)) dbusy_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            logic [CW-1:0]  n_new;
            logic [SW-1:0]  s_new;
            logic [SW-1:0]  s_abs;
            logic [DW-1:0]  smag;
            logic           neg;
            n_new = full ? count_r : count_r + 1'b1;
            s_new = full ? sum_r
                  : sum_r + SW'($signed(in_ch.data.sample[SAMPLE_BITS-1:0]));
            count_r <= n_new;
            sum_r   <= s_new;
            if (full) ovf_r <= 1'b1;
            if (in_ch.data.last) begin
              // mean = round(sum*256/n)
              neg   = s_new[SW-1];
              s_abs = neg ? -s_new : s_new;
              smag  = DW'(s_abs);
              dnum_r  <= (smag << 8) + DW'(n_new >> 1);
              dden_r  <= DW'(n_new);
              drem_r  <= '0;
              dcnt_r  <= DCW'(DW);
              dbusy_r <= 1'b1;
              dsign_r <= neg;
              first_r <= 1'b1;
              idx_r   <= '0;
              sumsq_r <= '0;
              mult_ph_r <= 1'b0;
            end
          end
        end
        ST_SUMSQ: begin
          if (first_r) begin
            if (div_done) begin
              mean_r  <= dsign_r ? -XW'(q_mag) : XW'(q_mag);
              first_r <= 1'b0;
            end
          end else if (!mult_ph_r) begin
            mult_ph_r <= 1'b1;          // store read in flight, data valid and squared next
          end else begin
            mult_ph_r <= 1'b0;
            if (idx_r == AW'(count_r - 1'b1)) begin
              dnum_r  <= DW'(sumsq_r + QW'(dev_sq));
              dden_r  <= DW'(count_r);
              drem_r  <= '0;
              dcnt_r  <= DCW'(DW);
              dbusy_r <= 1'b1;
              first_r <= 1'b1;
              idx_r   <= '0;
            end else begin
              sumsq_r <= sumsq_r + QW'(dev_sq);
              idx_r   <= idx_r + 1'b1;
            end
          end
        end
        ST_VARDIV: begin
          if (first_r) begin
            first_r <= 1'b0;
          end else if (div_done) begin
            sq_v_r   <= QW'(q_mag);
            sq_res_r <= '0;
            sq_bit_r <= QW'(1) << (((QW - 1) / 2) * 2);
            first_r  <= 1'b0;
          end
        end
        ST_SQRT: begin
          if (sq_bit_r != '0) begin
            if (sq_v_r >= sq_sum) begin
              sq_v_r   <= sq_v_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end else begin
            sd_r  <= sq_res_r;
            idx_r <= '0;
          end
        end
        ST_EMIT_RD: begin
          first_r <= 1'b1;
        end
        ST_EMIT_DIV: begin
          if (first_r) begin
            // z = round(d*2048/sd)
            dnum_r  <= (DW'(dev_mag) << 11) + DW'(sd_r >> 1);
            dden_r  <= DW'(sd_r);
            drem_r  <= '0;
            dcnt_r  <= DCW'(DW);
            dbusy_r <= 1'b1;
            dsign_r <= dev[XW-1];
            first_r <= 1'b0;
          end
        end
        ST_EMIT_OUT: begin
          if (!out_valid_r) begin
            logic big;
            big = (q_mag > DW'(dsign_r ? 32768 : 32767));
            if (sd_r == '0) begin
              out_z_r    <= '0;
              out_clip_r <= 1'b0;
            end else if (big) begin
              out_z_r    <= dsign_r ? 16'h8000 : 16'h7fff;
              out_clip_r <= 1'b1;
            end else begin
              out_z_r    <= dsign_r ? -q_mag[15:0] : q_mag[15:0];
              out_clip_r <= 1'b0;
            end
            out_final_r <= (idx_r == AW'(count_r - 1'b1));
            out_drop_r  <= ovf_r;
            out_valid_r <= 1'b1;
            if (idx_r == AW'(count_r - 1'b1)) begin
              // column done: the next one may load behind the waiting item
              count_r <= '0;
              sum_r   <= '0;
              ovf_r   <= 1'b0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register fields
  assign out_ch.valid            = out_valid_r;
  assign out_ch.data.normalized  = out_z_r;
  assign out_ch.data.clipped     = out_clip_r;
  assign out_ch.data.dropped_any = out_drop_r;
  assign out_ch.data.final_res   = out_final_r;
endmodule

// ----- design/zsn_checker.sv -----
// port-level checker for the z-score normalizer, bound to the top level
`timescale 1ns / 1ps
module zsn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_norm,
  input logic        out_final
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped under stall");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_norm, out_final}))
    else $error("result changed under stall");
  a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final |-> !in_ready) else $error("input open while emitting");
  a_fire_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("results not spaced");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");
endmodule

bind z_score_normalizer zsn_checker u_zsn_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_norm(out_ch.data.normalized),
  .out_final(out_ch.data.final_res)
);

// ----- bench/z_score_normalizer_test.sv -----
// testbench for the z-score normalizer: column stimulus, result prediction and checking
`timescale 1ns / 1ps
module z_score_normalizer_test
  import zsn_pkg::*;
();

  localparam int CAPACITY = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  zsn_if #(.payload_t(sample_item_t)) in_ch ();
  zsn_if #(.payload_t(zscore_item_t)) out_ch ();

  z_score_normalizer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // column state of the predictor
  logic signed [15:0] col_store[CAPACITY];
  longint             col_sum;
  int                 col_count;
  bit                 col_dropped;

  zscore_item_t zscore_q[$];
  int           n_errors = 0;
  int           n_results = 0;
  int           n_columns;
  int           n_dropped_cols;
  int           snd_idle_pct;
  int           rcv_idle_pct;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_cycles = 0;
  int           quiet_cycles = 0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // accepted sample: update the column, and on last queue the z-scores
  task automatic predict_zscores(sample_item_t it);
    longint mean;
    longint d;
    longint z;
    longint unsigned sumsq;
    longint unsigned sd;
    zscore_item_t r;
    if (col_count < CAPACITY) begin
      col_store[col_count] = it.sample;
      col_sum += it.sample;
      col_count++;
    end else begin
      col_dropped = 1'b1;
    end
    if (!it.last) return;
    if (col_count != 0) begin
      n_columns++;
      if (col_dropped) n_dropped_cols++;
      mean = round_div(col_sum * 256, col_count);
      sumsq = 0;
      for (int i = 0; i < col_count; i++) begin
        d = longint'(col_store[i]) * 256 - mean;
        sumsq += longint'(d * d);
      end
      sd = int_sqrt(sumsq / col_count);
      for (int i = 0; i < col_count; i++) begin
        z = 0;
        r.clipped = 1'b0;
        if (sd != 0) begin
          d = longint'(col_store[i]) * 256 - mean;
          z = round_div(d * 2048, longint'(sd));
          if (z > 32767) begin
            z = 32767;
            r.clipped = 1'b1;
          end
          if (z < -32768) begin
            z = -32768;
            r.clipped = 1'b1;
          end
        end
        r.normalized = z[15:0];
        r.dropped_any = col_dropped;
        r.final_res = (i == col_count - 1);
        zscore_q.push_back(r);
      end
    end
    col_sum = 0;
    col_count = 0;
    col_dropped = 1'b0;
  endtask

  // valid stays high once taken; the next call swaps the item, wait_drained drops valid
  task automatic send_sample(logic signed [15:0] s, bit lst);
    sample_item_t it;
    it.sample = s;
    it.last = lst;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_zscores(it);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(31))) - 16'sd16;
      2: return $signed(16'($urandom_range(2047))) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_column(int len, bit noisy);
    logic signed [15:0] base;
    base = rand_sample();
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(3) == 0) send_sample(base, i == len - 1);
      else send_sample(rand_sample(), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (zscore_q.size() != 0);
  endtask

  task automatic test_directed();
    send_sample(16'sh1234, 1'b1);               // one sample, zero spread
    send_sample(16'sh8000, 1'b0);               // both extremes
    send_sample(16'sh7fff, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(-16'sd77, i == 3);   // constant column
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(i == 6 ? 16'sh7fff : 16'sh8000, i == 6);
  endtask

  task automatic test_capacity();
    send_column(CAPACITY, 1'b0);
    send_column(CAPACITY + 6, 1'b0);            // the six items beyond capacity are dropped
    send_column(CAPACITY + 1, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: len = CAPACITY + $urandom_range(3);
        1: len = $urandom_range(CAPACITY, 20);
        default: len = $urandom_range(12, 1);
      endcase
      send_column(len, $urandom_range(1));
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    hold_req++;
    send_column(10, 1'b0);
    send_column(12, 1'b0);                      // input stalls while first column waits
    send_column(6, 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (zscore_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected item %p", out_ch.data);
      end else begin
        if (out_ch.data.normalized !== zscore_q[0].normalized ||
            out_ch.data.clipped !== zscore_q[0].clipped ||
            out_ch.data.dropped_any !== zscore_q[0].dropped_any ||
            out_ch.data.final_res !== zscore_q[0].final_res) begin
          n_errors++;
          if (n_errors <= 10)
            $display("item %0d: expected %p, got %p", n_results, zscore_q[0], out_ch.data);
        end
        void'(zscore_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("z_score_normalizer: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    col_sum = 0;
    col_count = 0;
    col_dropped = 1'b0;
    n_columns = 0;
    n_dropped_cols = 0;
    snd_idle_pct = 36;
    rcv_idle_pct = 54;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random(90);
    wait_drained();
    snd_idle_pct = 54;
    rcv_idle_pct = 36;
    test_backpressure();
    test_random(90);
    wait_drained();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(90);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d columns (%0d with dropped samples), %0d results checked",
             n_columns, n_dropped_cols, n_results);
    if (n_errors == 0 && zscore_q.size() == 0) begin
      $display("z_score_normalizer: match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, zscore_q.size());
      $display("z_score_normalizer: mismatch");
    end
    $finish;
  end
endmodule
